/* rtl/core/ftbm_pkg.sv */
// Shared definitions for the FSK tape byte modulator.
// Holds default sizes, register codes, reset values and the sine table builder.
// No dependencies.
package ftbm_pkg;

    // Default sizes handed to the top level.
    localparam int PHASE_BITS_DEF       = 32;
    localparam int TABLE_INDEX_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF      = 16;

    // Frame format: start bit, eight data bits, stop bit.
    localparam int DATA_BITS   = 8;
    localparam int FRAME_BITS  = DATA_BITS + 2;
    localparam int BITPOS_BITS = 4;
    localparam int COUNT_BITS  = 8;
    localparam int INC_BITS    = 32;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SAMPLES_PER_BIT = 2'd0,
        CFG_SPACE_INC       = 2'd1,
        CFG_MARK_INC        = 2'd2
    } t_cfg_reg;

    // Input opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_OFFER = 1'b1;

    // Register reset values.
    localparam logic [COUNT_BITS-1:0] SPB_RESET       = 8'd40;
    localparam logic [INC_BITS-1:0]   SPACE_INC_RESET = 32'd289739857;
    localparam logic [INC_BITS-1:0]   MARK_INC_RESET  = 32'd206957041;

    // pi in Q2.30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Quarter-wave sine entry q of a table with 2^tib entries, sb-bit samples.
    // Six Taylor terms in Q2.30, clamped at zero, scaled and rounded.
    function automatic logic [31:0] quarter_sine(input int q, input int tib, input int sb);
        logic [63:0]        x;
        logic [63:0]        t;
        logic signed [63:0] sum;
        logic [63:0]        amp;
        logic [63:0]        v;
        x   = (PI_Q30 * 64'(q) * 64'd2) >> tib;
        t   = x;
        sum = $signed(x);
        // term 1 (3!)
        t   = (t * x) >> 30;
        t   = (t * x) >> 30;
        t   = t / 64'd6;
        sum = sum - $signed(t);
        // term 2 (5!/3!)
        t   = (t * x) >> 30;
        t   = (t * x) >> 30;
        t   = t / 64'd20;
        sum = sum + $signed(t);
        // term 3
        t   = (t * x) >> 30;
        t   = (t * x) >> 30;
        t   = t / 64'd42;
        sum = sum - $signed(t);
        // term 4
        t   = (t * x) >> 30;
        t   = (t * x) >> 30;
        t   = t / 64'd72;
        sum = sum + $signed(t);
        // term 5
        t   = (t * x) >> 30;
        t   = (t * x) >> 30;
        t   = t / 64'd110;
        sum = sum - $signed(t);
        // term 6
        t   = (t * x) >> 30;
        t   = (t * x) >> 30;
        t   = t / 64'd156;
        sum = sum + $signed(t);
        if (sum < 0) begin
            sum = '0;
        end
        amp = (64'd1 << (sb - 1)) - 64'd1;
        v   = ($unsigned(sum) * amp + (64'd1 << 29)) >> 30;
        if (v > amp) begin
            v = amp;
        end
        return v[31:0];
    endfunction

endpackage

/* rtl/core/ftbm_sine_lookup.sv */
// Sine lookup from the top bits of the phase accumulator.
// Quarter-wave constant table with symmetry unfolding; uses ftbm_pkg.
module ftbm_sine_lookup #(
    parameter int TABLE_INDEX_BITS = ftbm_pkg::TABLE_INDEX_BITS_DEF,
    parameter int SAMPLE_BITS      = ftbm_pkg::SAMPLE_BITS_DEF
) (
    input  logic [TABLE_INDEX_BITS-1:0] i_index,
    output logic [SAMPLE_BITS-1:0]      o_sample
);
    import ftbm_pkg::*;

    localparam int QBITS  = TABLE_INDEX_BITS - 2;
    localparam int QDEPTH = 1 << QBITS;
    localparam logic [SAMPLE_BITS-1:0] PEAK =
        SAMPLE_BITS'(quarter_sine(QDEPTH, TABLE_INDEX_BITS, SAMPLE_BITS));

    logic [SAMPLE_BITS-1:0] w_quarter [QDEPTH];
    logic [1:0]             quad;
    logic [QBITS-1:0]       rem;
    logic [QBITS-1:0]       rem_mirror;
    logic [SAMPLE_BITS-1:0] mag;

    // Build the quarter-wave table at elaboration
    for (genvar g = 0; g < QDEPTH; g++) begin : g_rom
        localparam logic [SAMPLE_BITS-1:0] ENTRY =
            SAMPLE_BITS'(quarter_sine(g, TABLE_INDEX_BITS, SAMPLE_BITS));
        assign w_quarter[g] = ENTRY;
    end

    // Unfold quadrants: mirror odd quadrants, negate the lower half-wave
    always_comb begin
        quad       = i_index[TABLE_INDEX_BITS-1 -: 2];
        rem        = i_index[QBITS-1:0];
        rem_mirror = QBITS'(0) - rem;
        if (quad[0]) begin
            mag = (rem == '0) ? PEAK : w_quarter[rem_mirror];
        end else begin
            mag = w_quarter[rem];
        end
        o_sample = quad[1] ? (SAMPLE_BITS'(0) - mag) : mag;
    end

endmodule

/* rtl/core/fsk_tape_byte_modulator_top.sv */
// FSK tape byte modulator: 8N1 framing, phase-continuous mark/space tones.
// Result registered on each input transfer; throughput one item per cycle while the
// output is not stalled, set by the phase accumulator and bit timer updating together.
// Synchronous active-low reset: registers to defaults, phase 0, idle (mark tone).
// Uses ftbm_pkg and ftbm_sine_lookup.
module fsk_tape_byte_modulator_top #(
    parameter int PHASE_BITS       = ftbm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_INDEX_BITS = ftbm_pkg::TABLE_INDEX_BITS_DEF,
    parameter int SAMPLE_BITS      = ftbm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ftbm_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ftbm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [ftbm_pkg::DATA_BITS-1:0]      i_data_byte,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_sample,
    output logic                                o_accepted,
    output logic                                o_busy_res
);
    import ftbm_pkg::*;

    // configuration
    logic [COUNT_BITS-1:0] r_spb;
    logic [INC_BITS-1:0]   r_space_inc;
    logic [INC_BITS-1:0]   r_mark_inc;

    // modulator state
    logic [PHASE_BITS-1:0]  r_phase,  n_phase;
    logic [FRAME_BITS-1:0]  r_shift,  n_shift;
    logic [BITPOS_BITS-1:0] r_bitpos, n_bitpos;
    logic [COUNT_BITS-1:0]  r_count,  n_count;
    logic                   r_active, n_active;

    // result register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_accepted;
    logic                   r_busy;

    logic                   in_xfer;
    logic                   load;
    logic [FRAME_BITS-1:0]  eff_shift;
    logic [BITPOS_BITS-1:0] eff_bitpos;
    logic [COUNT_BITS-1:0]  eff_count;
    logic                   eff_active;
    logic                   tone_bit;
    logic [COUNT_BITS:0]    count_sum;
    logic [BITPOS_BITS-1:0] bitpos_inc;
    logic [SAMPLE_BITS-1:0] table_sample;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb       <= SPB_RESET;
            r_space_inc <= SPACE_INC_RESET;
            r_mark_inc  <= MARK_INC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SAMPLES_PER_BIT: r_spb       <= i_cfg_data[COUNT_BITS-1:0];
                CFG_SPACE_INC:       r_space_inc <= i_cfg_data[INC_BITS-1:0];
                CFG_MARK_INC:        r_mark_inc  <= i_cfg_data[INC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sample of the phase held before this transfer
    ftbm_sine_lookup #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_sine (
        .i_index  (r_phase[PHASE_BITS-1 -: TABLE_INDEX_BITS]),
        .o_sample (table_sample)
    );

    // Frame load, phase advance and bit timing
    always_comb begin
        load       = in_xfer && (i_opcode == OP_OFFER) && !r_active;
        eff_shift  = load ? {1'b1, i_data_byte, 1'b0} : r_shift;
        eff_bitpos = load ? '0 : r_bitpos;
        eff_count  = load ? '0 : r_count;
        eff_active = r_active || load;
        tone_bit   = eff_active ? eff_shift[0] : 1'b1;
        count_sum  = {1'b0, eff_count} + 1'b1;
        bitpos_inc = eff_bitpos + 1'b1;

        n_phase  = r_phase + PHASE_BITS'(tone_bit ? r_mark_inc : r_space_inc);
        n_shift  = eff_shift;
        n_bitpos = eff_bitpos;
        n_count  = eff_count;
        n_active = eff_active;
        if (eff_active) begin
            if (count_sum >= {1'b0, r_spb}) begin
                n_count  = '0;
                n_shift  = {1'b1, eff_shift[FRAME_BITS-1:1]};
                n_bitpos = bitpos_inc;
                if (bitpos_inc >= BITPOS_BITS'(FRAME_BITS)) begin
                    n_bitpos = '0;
                    n_active = 1'b0;
                    n_shift  = '1;
                end
            end else begin
                n_count = count_sum[COUNT_BITS-1:0];
            end
        end
    end

    // Advance state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_shift  <= '1;
            r_bitpos <= '0;
            r_count  <= '0;
            r_active <= 1'b0;
        end else if (in_xfer) begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_bitpos <= n_bitpos;
            r_count  <= n_count;
            r_active <= n_active;
        end
    end

    // Result register: fill on input transfer, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample   <= table_sample;
            r_accepted <= load;
            r_busy     <= n_active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = $signed(r_sample);
    assign o_accepted  = r_accepted;
    assign o_busy_res  = r_busy;

    // Idle holds the line at mark with the timer cleared
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_shift == '1 && r_count == '0 && r_bitpos == '0))
        else $error("idle state not cleared");

    // Bit position stays inside the frame
    a_bitpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bitpos < BITPOS_BITS'(FRAME_BITS)))
        else $error("bit position past end of frame");

    // A taken byte always starts a frame
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_accepted) |-> r_busy)
        else $error("accepted byte without busy frame");

    // An offer during a frame is never taken
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_active) |=> !r_accepted)
        else $error("byte taken while frame in flight");

endmodule
